// ===== rtl/core/price_level_book_bbo_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PRICE_LEVEL_BOOK_BBO_ASSERT_SVH
`define PRICE_LEVEL_BOOK_BBO_ASSERT_SVH
// Property that must hold at every edge outside reset.
`define PLB_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Property that must hold at the edge after a condition is seen.
`define PLB_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);
`endif

// ===== rtl/core/plb_pkg.sv =====
package plb_pkg;
  localparam int unsigned BookLevels   = 64;
  localparam int unsigned PendingDepth = 16;
  localparam int unsigned PriceW       = 48;
  localparam int unsigned SizeW        = 31;
  localparam int unsigned SymW         = 64;
  localparam int unsigned SumW         = 34;
  localparam int unsigned TopMax       = 8;
  localparam logic [3:0]  TopReset     = 4'd5;
  localparam logic [1:0]  RegTopLevels = 2'd0;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StPendFull = 2'd1,
    StBookFull = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmApply,
    FsmSelf,
    FsmSettle,
    FsmOut
  } fsm_e;

  // Command broadcast along a level chain.
  typedef struct packed {
    logic              en;
    logic [PriceW-1:0] price;
    logic [SizeW-1:0]  size;
  } lvl_cmd_t;
endpackage

// ===== rtl/core/plb_if.sv =====
interface plb_in_if;
  logic                      valid;
  logic                      ready;
  logic                      side;
  logic [63:0]               symbol;
  logic [47:0]               price;
  logic [30:0]               size;
  logic                      event_end;
  modport source (output valid, side, symbol, price, size, event_end, input ready);
  modport sink   (input valid, side, symbol, price, size, event_end, output ready);
endinterface

interface plb_out_if;
  logic        valid;
  logic        ready;
  logic        bbo_valid;
  logic [47:0] best_bid_price;
  logic [30:0] best_bid_size;
  logic [47:0] best_ask_price;
  logic [30:0] best_ask_size;
  logic        bbo_refreshed;
  logic [33:0] bid_top_sum;
  logic [33:0] ask_top_sum;
  logic [1:0]  status;
  modport source (output valid, bbo_valid, best_bid_price, best_bid_size, best_ask_price,
                  best_ask_size, bbo_refreshed, bid_top_sum, ask_top_sum, status,
                  input ready);
  modport sink   (input valid, bbo_valid, best_bid_price, best_bid_size, best_ask_price,
                  best_ask_size, bbo_refreshed, bid_top_sum, ask_top_sum, status,
                  output ready);
endinterface

// ===== rtl/core/plb_level_cell.sv =====
// One sorted level slot. Each cell compares the broadcast price with its own, uses
// its left neighbour's result, and shifts right on insert or left on removal.
module plb_level_cell #(
  parameter bit DESC = 1'b1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  plb_pkg::lvl_cmd_t          cmd_i,
  input  logic                       left_occ_i,
  input  logic [plb_pkg::PriceW-1:0] left_price_i,
  input  logic [plb_pkg::SizeW-1:0]  left_size_i,
  input  logic                       left_ahead_i,
  input  logic                       right_occ_i,
  input  logic [plb_pkg::PriceW-1:0] right_price_i,
  input  logic [plb_pkg::SizeW-1:0]  right_size_i,
  input  logic                       left_rm_i,
  input  logic                       full_i,
  input  logic                       hit_i,
  output logic                       occ_o,
  output logic [plb_pkg::PriceW-1:0] price_o,
  output logic [plb_pkg::SizeW-1:0]  size_o,
  output logic                       ahead_o,
  output logic                       match_o,
  output logic                       rm_o
);
  import plb_pkg::*;

  logic              occ_q, occ_d;
  logic [PriceW-1:0] price_q, price_d;
  logic [SizeW-1:0]  size_q, size_d;
  logic              ahead, match, rm;

  // This level sorts ahead of the incoming price.
  assign ahead = occ_q && (DESC ? (price_q > cmd_i.price) : (price_q < cmd_i.price));
  assign match = occ_q && (price_q == cmd_i.price);
  // Removal ripples right: a cell at or after the matched level takes its right neighbour.
  assign rm    = cmd_i.en && (cmd_i.size == '0) && (match || left_rm_i);

  // A nonzero size for a price already in the chain only updates its own cell; nothing shifts.
  always_comb begin
    occ_d   = occ_q;
    price_d = price_q;
    size_d  = size_q;
    if (cmd_i.en) begin
      if (cmd_i.size == '0) begin
        if (rm) begin
          occ_d   = right_occ_i;
          price_d = right_price_i;
          size_d  = right_size_i;
        end
      end else if (match) begin
        size_d = cmd_i.size;
      end else if (!full_i && !hit_i && !ahead && left_ahead_i) begin
        // First slot not ahead: new level lands here, the rest shift right.
        occ_d   = 1'b1;
        price_d = cmd_i.price;
        size_d  = cmd_i.size;
      end else if (!full_i && !hit_i && !ahead && !left_ahead_i && left_occ_i) begin
        occ_d   = left_occ_i;
        price_d = left_price_i;
        size_d  = left_size_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    size_q  <= size_d;
  end

  assign occ_o   = occ_q;
  assign price_o = price_q;
  assign size_o  = size_q;
  assign ahead_o = ahead;
  assign match_o = match;
  assign rm_o    = rm;
endmodule

// ===== rtl/core/plb_side.sv =====
// One side of the book: a chain of level cells plus the top-level sum.
module plb_side #(
  parameter int unsigned LEVELS = plb_pkg::BookLevels,
  parameter bit          DESC   = 1'b1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  plb_pkg::lvl_cmd_t          cmd_i,
  input  logic [3:0]                 top_i,
  output logic                       drop_o,
  output logic                       nonempty_o,
  output logic [plb_pkg::PriceW-1:0] best_price_o,
  output logic [plb_pkg::SizeW-1:0]  best_size_o,
  output logic [plb_pkg::SumW-1:0]   top_sum_o
);
  import plb_pkg::*;

  logic              occ   [LEVELS];
  logic [PriceW-1:0] price [LEVELS];
  logic [SizeW-1:0]  size  [LEVELS];
  logic              ahead [LEVELS];
  logic              match [LEVELS];
  logic              rm    [LEVELS];
  logic [LEVELS-1:0] match_v;
  logic              hit;
  logic              full;

  // The incoming price is already held somewhere in the chain.
  assign hit  = |match_v;
  assign full = occ[LEVELS-1] && !hit;

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    logic              l_occ, l_ahead, l_rm, r_occ;
    logic [PriceW-1:0] l_price, r_price;
    logic [SizeW-1:0]  l_size, r_size;
    if (g == 0) begin : g_first
      assign l_occ = 1'b0; assign l_price = '0; assign l_size = '0;
      assign l_ahead = 1'b1; assign l_rm = 1'b0;
    end else begin : g_mid
      assign l_occ = occ[g-1]; assign l_price = price[g-1]; assign l_size = size[g-1];
      assign l_ahead = ahead[g-1]; assign l_rm = rm[g-1];
    end
    if (g == LEVELS-1) begin : g_last
      assign r_occ = 1'b0; assign r_price = '0; assign r_size = '0;
    end else begin : g_inner
      assign r_occ = occ[g+1]; assign r_price = price[g+1]; assign r_size = size[g+1];
    end
    plb_level_cell #(.DESC(DESC)) u_cell (
      .clk_i, .rst_ni, .cmd_i,
      .left_occ_i(l_occ), .left_price_i(l_price), .left_size_i(l_size),
      .left_ahead_i(l_ahead), .right_occ_i(r_occ), .right_price_i(r_price),
      .right_size_i(r_size), .left_rm_i(l_rm), .full_i(full), .hit_i(hit),
      .occ_o(occ[g]), .price_o(price[g]), .size_o(size[g]), .ahead_o(ahead[g]),
      .match_o(match[g]), .rm_o(rm[g])
    );
    assign match_v[g] = match[g];
  end

  assign drop_o       = cmd_i.en && (cmd_i.size != '0) && full;
  assign nonempty_o   = occ[0];
  assign best_price_o = price[0];
  assign best_size_o  = size[0];

  // Sum over the first few cells; at most eight adds of narrow values.
  always_comb begin
    logic [SumW-1:0] s;
    s = '0;
    for (int i = 0; i < TopMax; i++) begin
      if (i < LEVELS && occ[i] && (i < int'(top_i))) s = s + SumW'(size[i]);
    end
    top_sum_o = s;
  end
endmodule

// ===== rtl/core/price_level_book_bbo.sv =====
// Price-level book with best bid and offer.
// Input channel in_if carries one update per item: side, symbol, price, size
// and event_end. Output channel out_if returns one result item per input.
// An update without event_end is stored in the pending buffer if there is room;
// an event end replays, one per cycle, the buffer entries of its symbol and then
// itself. Each applied update goes into a chain of level cells that inserts,
// updates or removes a level.
// A held update passes through the Settle and Out states before its result is
// registered; an event end passes through Scan, Apply, Self, Settle and Out,
// and the pending scan visits one entry per cycle.
// One item is in flight at a time; in_if.ready is high only while idle.
// The next item can be taken in the cycle after the result is taken.
// The result sits in an output register until taken; while the receiver
// stalls no new item is accepted.
// Reset empties both tables and the pending buffer, clears the held BBO and
// sets top_levels to 5. Configuration goes over the APB-style port.
module price_level_book_bbo #(
  parameter int unsigned BOOK_LEVELS   = plb_pkg::BookLevels,
  parameter int unsigned PENDING_DEPTH = plb_pkg::PendingDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plb_in_if.sink      in_if,
  plb_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import plb_pkg::*;
  localparam int unsigned PW = $clog2(PENDING_DEPTH);

  fsm_e state_q, state_d;
  logic [3:0] top_q;

  // Pending memory.
  logic              p_side  [PENDING_DEPTH];
  logic [SymW-1:0]   p_sym   [PENDING_DEPTH];
  logic [PriceW-1:0] p_price [PENDING_DEPTH];
  logic [SizeW-1:0]  p_size  [PENDING_DEPTH];
  logic [PW:0]       cnt_q, rd_q, wr_q;
  logic              rd_side_q;
  logic [SymW-1:0]   rd_sym_q;
  logic [PriceW-1:0] rd_price_q;
  logic [SizeW-1:0]  rd_size_q;
  logic              rd_vld_q;

  logic              it_side_q, it_end_q;
  logic [SymW-1:0]   it_sym_q;
  logic [PriceW-1:0] it_price_q;
  logic [SizeW-1:0]  it_size_q;
  logic              dropped_q, ovf_q;

  lvl_cmd_t bid_cmd, ask_cmd;
  logic bid_drop, ask_drop, bid_ne, ask_ne;
  logic [PriceW-1:0] bid_p, ask_p;
  logic [SizeW-1:0]  bid_s, ask_s;
  logic [SumW-1:0]   bid_sum, ask_sum;

  logic              o_vld_q, o_bv_q, o_ref_q;
  logic [PriceW-1:0] o_bp_q, o_ap_q;
  logic [SizeW-1:0]  o_bs_q, o_as_q;
  logic [SumW-1:0]   o_bsum_q, o_asum_q;
  logic [1:0]        o_st_q;

  logic accept, apply_pend, apply_self, rd_en;

  assign pready = 1'b1;
  assign prdata = (paddr == RegTopLevels) ? {28'd0, top_q} : 32'd0;
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == FsmIdle) && !o_vld_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle:   if (accept) state_d = in_if.event_end ? FsmScan : FsmSettle;
      FsmScan:   if (rd_q == cnt_q) state_d = FsmApply;
      FsmApply:  state_d = FsmSelf;
      FsmSelf:   state_d = FsmSettle;
      FsmSettle: state_d = FsmOut;
      FsmOut:    state_d = FsmIdle;
      default:   state_d = FsmIdle;
    endcase
  end

  // Stage outputs.
  always_comb begin
    rd_en      = (state_q == FsmScan) && (rd_q != cnt_q);
    apply_pend = rd_vld_q && (rd_sym_q == it_sym_q) &&
                 (state_q == FsmScan || state_q == FsmApply);
    apply_self = (state_q == FsmSelf);
  end

  always_comb begin
    bid_cmd = '0; ask_cmd = '0;
    if (apply_pend) begin
      bid_cmd = '{en: !rd_side_q, price: rd_price_q, size: rd_size_q};
      ask_cmd = '{en: rd_side_q, price: rd_price_q, size: rd_size_q};
    end else if (apply_self) begin
      bid_cmd = '{en: !it_side_q, price: it_price_q, size: it_size_q};
      ask_cmd = '{en: it_side_q, price: it_price_q, size: it_size_q};
    end
  end

  plb_side #(.LEVELS(BOOK_LEVELS), .DESC(1'b1)) u_bid (
    .clk_i, .rst_ni, .cmd_i(bid_cmd), .top_i(top_q), .drop_o(bid_drop),
    .nonempty_o(bid_ne), .best_price_o(bid_p), .best_size_o(bid_s), .top_sum_o(bid_sum));
  plb_side #(.LEVELS(BOOK_LEVELS), .DESC(1'b0)) u_ask (
    .clk_i, .rst_ni, .cmd_i(ask_cmd), .top_i(top_q), .drop_o(ask_drop),
    .nonempty_o(ask_ne), .best_price_o(ask_p), .best_size_o(ask_s), .top_sum_o(ask_sum));

  // Pending memory: write on push and on compaction, read one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (accept && !in_if.event_end && cnt_q < (PW+1)'(PENDING_DEPTH)) begin
      p_side[cnt_q[PW-1:0]]  <= in_if.side;
      p_sym[cnt_q[PW-1:0]]   <= in_if.symbol;
      p_price[cnt_q[PW-1:0]] <= in_if.price;
      p_size[cnt_q[PW-1:0]]  <= in_if.size;
    end else if (rd_vld_q && rd_sym_q != it_sym_q) begin
      p_side[wr_q[PW-1:0]]  <= rd_side_q;
      p_sym[wr_q[PW-1:0]]   <= rd_sym_q;
      p_price[wr_q[PW-1:0]] <= rd_price_q;
      p_size[wr_q[PW-1:0]]  <= rd_size_q;
    end
    if (rd_en) begin
      rd_side_q  <= p_side[rd_q[PW-1:0]];
      rd_sym_q   <= p_sym[rd_q[PW-1:0]];
      rd_price_q <= p_price[rd_q[PW-1:0]];
      rd_size_q  <= p_size[rd_q[PW-1:0]];
    end
    if (accept) begin
      it_side_q <= in_if.side; it_sym_q <= in_if.symbol; it_price_q <= in_if.price;
      it_size_q <= in_if.size; it_end_q <= in_if.event_end;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle; top_q <= TopReset; cnt_q <= '0; rd_q <= '0; wr_q <= '0;
      rd_vld_q <= 1'b0; dropped_q <= 1'b0; ovf_q <= 1'b0; o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && paddr == RegTopLevels) top_q <= pwdata[3:0];
      rd_vld_q <= rd_en;
      if (rd_vld_q && rd_sym_q != it_sym_q) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      if (bid_drop || ask_drop) dropped_q <= 1'b1;
      if (accept) begin
        rd_q <= '0; wr_q <= '0; dropped_q <= 1'b0;
        ovf_q <= !in_if.event_end && cnt_q >= (PW+1)'(PENDING_DEPTH);
        if (!in_if.event_end && cnt_q < (PW+1)'(PENDING_DEPTH)) cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == FsmSelf) cnt_q <= wr_q;
      if (state_q == FsmOut) o_vld_q <= 1'b1;
      else if (out_if.valid && out_if.ready) o_vld_q <= 1'b0;
    end
  end

  // Held BBO and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_bv_q <= 1'b0; o_bp_q <= '0; o_bs_q <= '0; o_ap_q <= '0; o_as_q <= '0;
    end else if (state_q == FsmSettle && it_end_q) begin
      o_bv_q <= bid_ne && ask_ne;
      o_bp_q <= (bid_ne && ask_ne) ? bid_p : '0;
      o_bs_q <= (bid_ne && ask_ne) ? bid_s : '0;
      o_ap_q <= (bid_ne && ask_ne) ? ask_p : '0;
      o_as_q <= (bid_ne && ask_ne) ? ask_s : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FsmSettle) begin
      o_ref_q  <= it_end_q;
      o_bsum_q <= bid_sum;
      o_asum_q <= ask_sum;
      o_st_q   <= ovf_q ? StPendFull : (dropped_q ? StBookFull : StOk);
    end
  end

  assign out_if.valid          = o_vld_q;
  assign out_if.bbo_valid      = o_bv_q;
  assign out_if.best_bid_price = o_bp_q;
  assign out_if.best_bid_size  = o_bs_q;
  assign out_if.best_ask_price = o_ap_q;
  assign out_if.best_ask_size  = o_as_q;
  assign out_if.bbo_refreshed  = o_ref_q;
  assign out_if.bid_top_sum    = o_bsum_q;
  assign out_if.ask_top_sum    = o_asum_q;
  assign out_if.status         = o_st_q;
endmodule

// ===== rtl/core/plb_checker.sv =====
`include "price_level_book_bbo_assert.svh"
// Port-level checks of the book.
module plb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic       refreshed_i,
  input logic       pready_i
);
  import plb_pkg::*;

  `PLB_ASSERT(a_no_accept_while_result, clk_i, rst_ni, out_valid_i |-> !in_ready_i, "input taken with result waiting")
  `PLB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result lost")
  `PLB_ASSERT(a_status_code, clk_i, rst_ni, out_valid_i |-> (status_i == StOk || status_i == StPendFull || status_i == StBookFull), "bad status")
  `PLB_ASSERT(a_pend_full_not_refresh, clk_i, rst_ni, (out_valid_i && status_i == StPendFull) |-> !refreshed_i, "overflow on event end")
  `PLB_ASSERT(a_pready, clk_i, rst_ni, pready_i, "pready low")
endmodule

bind price_level_book_bbo plb_checker u_plb_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .status_i(out_if.status),
  .refreshed_i(out_if.bbo_refreshed), .pready_i(pready)
);
